// ===== rtl/clr_pkg.sv =====
`timescale 1ns / 1ps
// Package for the clipped line rasterizer: coordinate width, default frame size,
// request codes and the sequencer state type. No dependencies.
package clr_pkg;

    // Signed width of every coordinate field of a request
    localparam int COORD_W = 12;

    // Default frame store geometry
    localparam int FRAME_WIDTH_DEF  = 80;
    localparam int FRAME_HEIGHT_DEF = 40;

    // Request codes
    localparam logic [1:0] ACT_DRAW  = 2'd0;
    localparam logic [1:0] ACT_READ  = 2'd1;
    localparam logic [1:0] ACT_CLEAR = 2'd2;

    // Sequencer states
    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_DRAW,
        S_DRAIN,
        S_READ,
        S_READ_WAIT,
        S_RESP
    } t_state;

endpackage

// ===== rtl/clipped_line_rasterizer.sv =====
`timescale 1ns / 1ps
// A draw walks its line of N = max(|dx|,|dy|) + 1 pixels one pixel per cycle through the
// row memory; a clear writes one row per cycle; unused code 3 goes straight to the result.
// One request is in flight at a time. After reset a clearing pass blanks the store; no
// request is accepted until it ends.
// Depends on clr_pkg.
module clipped_line_rasterizer
    import clr_pkg::*;
#(
    parameter int FRAME_WIDTH  = FRAME_WIDTH_DEF,
    parameter int FRAME_HEIGHT = FRAME_HEIGHT_DEF
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_valid,
    output logic                      o_ready,
    input  logic [1:0]                i_action,
    input  logic signed [COORD_W-1:0] i_start_x,
    input  logic signed [COORD_W-1:0] i_start_y,
    input  logic signed [COORD_W-1:0] i_end_x,
    input  logic signed [COORD_W-1:0] i_end_y,
    output logic                      o_valid,
    input  logic                      i_ready,
    output logic                      o_pixel_value
);

    localparam int RW = (FRAME_HEIGHT > 1) ? $clog2(FRAME_HEIGHT) : 1;
    localparam int CI = (FRAME_WIDTH > 1) ? $clog2(FRAME_WIDTH) : 1;
    localparam int EW = COORD_W + 3;
    localparam logic signed [COORD_W:0] W_LIM = (COORD_W+1)'(FRAME_WIDTH);
    localparam logic signed [COORD_W:0] H_LIM = (COORD_W+1)'(FRAME_HEIGHT);
    localparam logic [RW-1:0] LAST_ROW = RW'(FRAME_HEIGHT - 1);

    // Frame store: one row of pixels per entry
    logic [FRAME_WIDTH-1:0] mem [FRAME_HEIGHT];
    logic [FRAME_WIDTH-1:0] r_rdata;
    logic [RW-1:0]          rd_addr;
    logic                   wr_en;
    logic [RW-1:0]          wr_addr;
    logic [FRAME_WIDTH-1:0] wr_data;

    // Sequencer and walker state
    t_state r_state, n_state;
    logic signed [COORD_W-1:0] r_x, n_x, r_y, n_y, r_ex, n_ex, r_ey, n_ey;
    logic signed [EW-1:0]      r_dx, n_dx, r_dy, n_dy, r_err, n_err;
    logic                      r_sx, n_sx, r_sy, n_sy;
    logic [RW-1:0]             r_clr_row, n_clr_row;
    logic                      r_clr_reply, n_clr_reply;
    logic                      r_rd_ok, n_rd_ok;
    logic                      r_res, n_res;

    // Pixel write stage
    logic          r_b_valid, n_b_valid;
    logic [RW-1:0] r_b_row, n_b_row;
    logic [CI-1:0] r_b_col, n_b_col;

    // Last write, for forwarding into the next read-modify-write
    logic                   r_w_last;
    logic [RW-1:0]          r_w_row;
    logic [FRAME_WIDTH-1:0] r_w_data;

    // Result register
    logic r_out_valid, n_out_valid;
    logic r_pixel, n_pixel;

    logic                      accept;
    logic                      at_end;
    logic                      pix_on;
    logic signed [EW:0]        e2;
    logic                      step_x, step_y;
    logic signed [COORD_W:0]   diff_x, diff_y;
    logic [FRAME_WIDTH-1:0]    row_base;

    function automatic logic on_frame(input logic signed [COORD_W-1:0] x,
                                      input logic signed [COORD_W-1:0] y);
        logic signed [COORD_W:0] xe;
        logic signed [COORD_W:0] ye;
        xe = {x[COORD_W-1], x};
        ye = {y[COORD_W-1], y};
        return (xe >= 0) && (xe < W_LIM) && (ye >= 0) && (ye < H_LIM);
    endfunction

    assign accept  = i_valid && o_ready;
    assign o_ready = (r_state == S_IDLE);
    assign o_valid = r_out_valid;
    assign o_pixel_value = r_pixel;

    // Walker decisions for the current pixel
    assign at_end = (r_x == r_ex) && (r_y == r_ey);
    assign pix_on = on_frame(r_x, r_y);
    assign e2     = {r_err, 1'b0};
    assign step_x = e2 > -$signed({r_dy[EW-1], r_dy});
    assign step_y = e2 < $signed({r_dx[EW-1], r_dx});
    assign diff_x = {i_end_x[COORD_W-1], i_end_x} - {i_start_x[COORD_W-1], i_start_x};
    assign diff_y = {i_end_y[COORD_W-1], i_end_y} - {i_start_y[COORD_W-1], i_start_y};

    // Next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_CLEAR: begin
                if (r_clr_row == LAST_ROW) begin
                    n_state = r_clr_reply ? S_RESP : S_IDLE;
                end
            end
            S_IDLE: begin
                if (accept) begin
                    case (i_action)
                        ACT_DRAW:  n_state = S_DRAW;
                        ACT_READ:  n_state = S_READ;
                        ACT_CLEAR: n_state = S_CLEAR;
                        default:   n_state = S_RESP;
                    endcase
                end
            end
            S_DRAW: begin
                if (at_end) begin
                    n_state = S_DRAIN;
                end
            end
            S_DRAIN:     n_state = S_RESP;
            S_READ:      n_state = S_READ_WAIT;
            S_READ_WAIT: n_state = S_RESP;
            S_RESP: begin
                if (!r_out_valid || i_ready) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // Datapath and result updates
    always_comb begin
        n_x = r_x;  n_y = r_y;  n_ex = r_ex;  n_ey = r_ey;
        n_dx = r_dx;  n_dy = r_dy;  n_err = r_err;  n_sx = r_sx;  n_sy = r_sy;
        n_clr_row   = r_clr_row;
        n_clr_reply = r_clr_reply;
        n_rd_ok     = r_rd_ok;
        n_res       = r_res;
        n_b_valid   = 1'b0;
        n_b_row     = r_y[RW-1:0];
        n_b_col     = r_x[CI-1:0];
        n_out_valid = r_out_valid && !i_ready;
        n_pixel     = r_pixel;
        rd_addr     = r_y[RW-1:0];
        case (r_state)
            S_CLEAR: begin
                n_clr_row = r_clr_row + RW'(1);
            end
            S_IDLE: begin
                if (accept) begin
                    n_x  = i_start_x;
                    n_y  = i_start_y;
                    n_ex = i_end_x;
                    n_ey = i_end_y;
                    n_dx = EW'(diff_x[COORD_W] ? -diff_x : diff_x);
                    n_dy = EW'(diff_y[COORD_W] ? -diff_y : diff_y);
                    n_err = EW'(diff_x[COORD_W] ? -diff_x : diff_x)
                          - EW'(diff_y[COORD_W] ? -diff_y : diff_y);
                    n_sx = i_start_x < i_end_x;
                    n_sy = i_start_y < i_end_y;
                    n_res = 1'b0;
                    n_clr_row   = '0;
                    n_clr_reply = 1'b1;
                end
            end
            S_DRAW: begin
                // Read the pixel's row now, set the bit next cycle
                n_b_valid = pix_on;
                if (!at_end) begin
                    if (step_x) begin
                        n_x = r_x + (r_sx ? COORD_W'(1) : {COORD_W{1'b1}});
                    end
                    if (step_y) begin
                        n_y = r_y + (r_sy ? COORD_W'(1) : {COORD_W{1'b1}});
                    end
                    n_err = r_err - (step_x ? r_dy : EW'(0)) + (step_y ? r_dx : EW'(0));
                end
            end
            S_READ: begin
                n_rd_ok = pix_on;
            end
            S_READ_WAIT: begin
                n_res = r_rd_ok && r_rdata[r_x[CI-1:0]];
            end
            S_RESP: begin
                if (!r_out_valid || i_ready) begin
                    n_out_valid = 1'b1;
                    n_pixel     = r_res;
                end
            end
            default: ;
        endcase
    end

    // Write port: clearing sweep or pixel set with forwarding of the last write
    always_comb begin
        row_base = (r_w_last && (r_w_row == r_b_row)) ? r_w_data : r_rdata;
        if (r_state == S_CLEAR) begin
            wr_en   = 1'b1;
            wr_addr = r_clr_row;
            wr_data = '0;
        end else begin
            wr_en   = r_b_valid;
            wr_addr = r_b_row;
            wr_data = row_base | (FRAME_WIDTH'(1) << r_b_col);
        end
    end

    // Row memory, one write and one registered read per cycle
    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        r_rdata <= mem[rd_addr];
    end

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLEAR;
            r_clr_row   <= '0;
            r_clr_reply <= 1'b0;
            r_b_valid   <= 1'b0;
            r_w_last    <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_clr_row   <= n_clr_row;
            r_clr_reply <= n_clr_reply;
            r_b_valid   <= n_b_valid;
            r_w_last    <= wr_en;
            r_out_valid <= n_out_valid;
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        r_x     <= n_x;
        r_y     <= n_y;
        r_ex    <= n_ex;
        r_ey    <= n_ey;
        r_dx    <= n_dx;
        r_dy    <= n_dy;
        r_err   <= n_err;
        r_sx    <= n_sx;
        r_sy    <= n_sy;
        r_rd_ok <= n_rd_ok;
        r_res   <= n_res;
        r_b_row <= n_b_row;
        r_b_col <= n_b_col;
        r_w_row <= wr_addr;
        r_w_data <= wr_data;
        r_pixel <= n_pixel;
    end

endmodule

// ===== rtl/clr_checker.sv =====
`timescale 1ns / 1ps
// Port-level checks for the clipped line rasterizer, bound to the top level.
// Depends on clr_pkg and clipped_line_rasterizer.
module clr_checker
    import clr_pkg::*;
(
    input logic                      i_clk,
    input logic                      i_rst_n,
    input logic                      i_valid,
    input logic                      o_ready,
    input logic [1:0]                i_action,
    input logic                      o_valid,
    input logic                      i_ready,
    input logic                      o_pixel_value
);

    // Codes of requests whose results are still owed, oldest at the head
    logic [1:0] r_act_head;
    logic [1:0] r_act_next;
    logic [1:0] r_act_cnt;
    logic       req_push;
    logic       res_pop;

    assign req_push = i_valid && o_ready;
    assign res_pop  = o_valid && i_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_act_head <= ACT_DRAW;
            r_act_next <= ACT_DRAW;
            r_act_cnt  <= 2'd0;
        end else begin
            case ({req_push, res_pop})
                2'b10: begin
                    if (r_act_cnt == 2'd0) begin
                        r_act_head <= i_action;
                    end else begin
                        r_act_next <= i_action;
                    end
                    r_act_cnt <= r_act_cnt + 2'd1;
                end
                2'b01: begin
                    r_act_head <= r_act_next;
                    r_act_cnt  <= r_act_cnt - 2'd1;
                end
                2'b11: begin
                    if (r_act_cnt == 2'd1) begin
                        r_act_head <= i_action;
                    end else begin
                        r_act_head <= r_act_next;
                        r_act_next <= i_action;
                    end
                end
                default: ;
            endcase
        end
    end

    // Reset leaves no result pending and holds off requests during the clearing pass
    a_reset_quiet: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid && !o_ready)
        else $error("result or ready high straight after reset");

    // One request at a time: ready drops after an acceptance
    a_one_in_flight: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && o_ready |=> !o_ready)
        else $error("request accepted while another is in flight");

    // Only a read can return a set pixel
    a_set_only_on_read: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_pixel_value |-> r_act_head == ACT_READ)
        else $error("set pixel returned for a request other than read");

    // A stalled result holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid && $stable(o_pixel_value))
        else $error("stalled result dropped or changed");

endmodule

bind clipped_line_rasterizer clr_checker u_clr_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .i_valid       (i_valid),
    .o_ready       (o_ready),
    .i_action      (i_action),
    .o_valid       (o_valid),
    .i_ready       (i_ready),
    .o_pixel_value (o_pixel_value)
);
